FILE: rtl/assert_macros.svh
// assertion macros, included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define KMS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define KMS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define KMS_ASSERT(label, clk, rst_n, prop)
`define KMS_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

FILE: rtl/kms_pkg.sv
// types and constants of the kruskal edge selector
package kms_pkg;
    localparam int NODE_W   = 4;
    localparam int WEIGHT_W = 16;
    localparam int EDGE_W   = 2 * NODE_W + WEIGHT_W;
    localparam int CFG_W    = 5;
    localparam logic [CFG_W-1:0] NODE_COUNT_RST = 5'd16;

    typedef enum logic [3:0] {
        S_LOAD,
        S_RANK_RD,
        S_RANK_CAP,
        S_RANK_SCAN,
        S_RANK_WR,
        S_INIT,
        S_EDGE_RD,
        S_EDGE_CAP,
        S_LBL_A,
        S_LBL_B,
        S_SWEEP,
        S_EMIT
    } t_state;
endpackage

FILE: rtl/kms_ram.sv
// single write, single read synchronous memory with registered read data
module kms_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: rtl/kruskal_mst_edge_selector.sv
// kruskal minimum spanning forest edge selector, top level
// load: one edge per cycle into the edge store, no result
// after last: rank sort of the c stored edges, label init of the n nodes, then for
// each edge a label lookup and, where needed, a label sweep over the label memory
// one result strobe per stored edge, receiver cannot stall, busy high until done
// synchronous active-low reset clears control state, node_count resets to 16
module kruskal_mst_edge_selector #(
    parameter int MAX_NODES = 16,
    parameter int MAX_EDGES = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [kms_pkg::NODE_W-1:0]     i_node_a,
    input  logic [kms_pkg::NODE_W-1:0]     i_node_b,
    input  logic signed [kms_pkg::WEIGHT_W-1:0] i_weight,
    input  logic                           i_last,
    input  logic                           i_cfg_we,
    input  logic [kms_pkg::CFG_W-1:0]      i_cfg_wdata,
    output logic                           o_valid,
    output logic [kms_pkg::NODE_W-1:0]     o_out_node_a,
    output logic [kms_pkg::NODE_W-1:0]     o_out_node_b,
    output logic signed [kms_pkg::WEIGHT_W-1:0] o_out_weight,
    output logic                           o_in_tree,
    output logic                           o_overflow,
    output logic                           o_last_result
);
    localparam int EW   = $clog2(MAX_EDGES);
    localparam int CW   = $clog2(MAX_EDGES + 1);
    localparam int NW   = $clog2(MAX_NODES);
    localparam int NCW  = $clog2(MAX_NODES + 1);
    localparam int LW   = $clog2(2 * MAX_NODES);
    localparam int CMPW = NCW + kms_pkg::NODE_W + 1;
    localparam int XW   = NW + kms_pkg::NODE_W;
    localparam int NW4  = kms_pkg::NODE_W;
    localparam int WW   = kms_pkg::WEIGHT_W;
    localparam int EDW  = kms_pkg::EDGE_W;

    kms_pkg::t_state r_state, n_state;

    logic [kms_pkg::CFG_W-1:0] r_node_count;
    logic [CW-1:0]   r_count;
    logic            r_dropped;
    logic [NCW-1:0]  r_n;
    logic [EW-1:0]   r_i, r_jp, r_rank, r_e;
    logic [EDW-1:0]  r_cur;
    logic [NW-1:0]   r_k;
    logic [LW-1:0]   r_fresh, r_la;
    logic            r_take;

    logic            st_we, so_we, lb_we;
    logic [EW-1:0]   st_waddr, st_raddr, so_raddr;
    logic [EDW-1:0]  st_wdata, st_rdata, so_rdata;
    logic [NW-1:0]   lb_waddr, lb_raddr;
    logic [LW-1:0]   lb_wdata, lb_rdata;

    logic            accept;
    logic [NCW-1:0]  n_clamp;
    logic            w_less;
    logic [NW4-1:0]  ed_a, ed_b;
    logic            ed_ok;
    logic [XW-1:0]   ext_a, ext_b;
    logic            jp_end, i_end, k_end, e_end;

    assign accept = start && !busy;
    assign busy   = (r_state != kms_pkg::S_LOAD);

    always_comb begin
        if (r_node_count == '0) begin
            n_clamp = NCW'(1);
        end else if (8'(r_node_count) > 8'(MAX_NODES)) begin
            n_clamp = NCW'(MAX_NODES);
        end else begin
            n_clamp = NCW'(r_node_count);
        end
    end

    // stable order: earlier load wins ties
    assign w_less = ($signed(st_rdata[WW-1:0]) < $signed(r_cur[WW-1:0])) ||
                    ((st_rdata[WW-1:0] == r_cur[WW-1:0]) && (r_jp < r_i));

    assign ed_a  = so_rdata[EDW-1 -: NW4];
    assign ed_b  = so_rdata[EDW-NW4-1 -: NW4];
    assign ed_ok = (CMPW'(ed_a) < CMPW'(r_n)) && (CMPW'(ed_b) < CMPW'(r_n)) &&
                   (ed_a != ed_b);
    assign ext_a = XW'(ed_a);
    assign ext_b = XW'(r_cur[EDW-NW4-1 -: NW4]);

    assign jp_end = (CW'(r_jp) + CW'(1) == r_count);
    assign i_end  = (CW'(r_i) + CW'(1) == r_count);
    assign e_end  = (CW'(r_e) + CW'(1) == r_count);
    assign k_end  = (NCW'(r_k) + NCW'(1) == r_n);

    always_comb begin
        n_state  = r_state;
        st_we    = 1'b0;
        st_waddr = r_count[EW-1:0];
        st_wdata = {i_node_a, i_node_b, i_weight};
        st_raddr = r_jp + EW'(1);
        so_we    = 1'b0;
        so_raddr = r_e;
        lb_we    = 1'b0;
        lb_waddr = r_k;
        lb_wdata = LW'(r_k);
        lb_raddr = r_k;
        case (r_state)
            kms_pkg::S_LOAD: begin
                if (accept) begin
                    st_we = (r_count < CW'(MAX_EDGES));
                    if (i_last) begin
                        n_state = kms_pkg::S_RANK_RD;
                    end
                end
            end
            kms_pkg::S_RANK_RD: begin
                st_raddr = r_i;
                n_state  = kms_pkg::S_RANK_CAP;
            end
            kms_pkg::S_RANK_CAP: begin
                st_raddr = '0;
                n_state  = kms_pkg::S_RANK_SCAN;
            end
            kms_pkg::S_RANK_SCAN: begin
                if (jp_end) begin
                    n_state = kms_pkg::S_RANK_WR;
                end
            end
            kms_pkg::S_RANK_WR: begin
                so_we = 1'b1;
                n_state = i_end ? kms_pkg::S_INIT : kms_pkg::S_RANK_RD;
            end
            kms_pkg::S_INIT: begin
                lb_we = 1'b1;
                if (k_end) begin
                    n_state = kms_pkg::S_EDGE_RD;
                end
            end
            kms_pkg::S_EDGE_RD: begin
                n_state = kms_pkg::S_EDGE_CAP;
            end
            kms_pkg::S_EDGE_CAP: begin
                lb_raddr = ext_a[NW-1:0];
                n_state  = ed_ok ? kms_pkg::S_LBL_A : kms_pkg::S_EMIT;
            end
            kms_pkg::S_LBL_A: begin
                lb_raddr = ext_b[NW-1:0];
                n_state  = kms_pkg::S_LBL_B;
            end
            kms_pkg::S_LBL_B: begin
                lb_raddr = '0;
                n_state  = (lb_rdata == r_la) ? kms_pkg::S_EMIT : kms_pkg::S_SWEEP;
            end
            kms_pkg::S_SWEEP: begin
                // label data of node r_k present, next node read in flight
                lb_raddr = r_k + NW'(1);
                lb_wdata = r_fresh;
                lb_we    = 1'b1;
                if (k_end) begin
                    n_state = kms_pkg::S_EMIT;
                end
            end
            kms_pkg::S_EMIT: begin
                n_state = e_end ? kms_pkg::S_LOAD : kms_pkg::S_EDGE_RD;
            end
            default: begin
                n_state = kms_pkg::S_LOAD;
            end
        endcase
    end

    // sweep writes back only labels of the two merging components
    logic [LW-1:0] r_lb;
    logic          sweep_hit;
    assign sweep_hit = (lb_rdata == r_la) || (lb_rdata == r_lb);

    logic lb_we_q;
    assign lb_we_q = lb_we && ((r_state != kms_pkg::S_SWEEP) || sweep_hit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kms_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= kms_pkg::NODE_COUNT_RST;
            r_count      <= '0;
            r_dropped    <= 1'b0;
            o_valid      <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_we) begin
                r_node_count <= i_cfg_wdata;
            end
            case (r_state)
                kms_pkg::S_LOAD: begin
                    if (accept) begin
                        if (r_count < CW'(MAX_EDGES)) begin
                            r_count <= r_count + CW'(1);
                        end else begin
                            r_dropped <= 1'b1;
                        end
                        r_n <= n_clamp;
                        r_i <= '0;
                    end
                end
                kms_pkg::S_RANK_CAP: begin
                    r_cur  <= st_rdata;
                    r_jp   <= '0;
                    r_rank <= '0;
                end
                kms_pkg::S_RANK_SCAN: begin
                    r_rank <= r_rank + EW'(w_less);
                    r_jp   <= r_jp + EW'(1);
                end
                kms_pkg::S_RANK_WR: begin
                    r_i <= r_i + EW'(1);
                    r_k <= '0;
                end
                kms_pkg::S_INIT: begin
                    r_k     <= r_k + NW'(1);
                    r_fresh <= LW'(r_n);
                    r_e     <= '0;
                end
                kms_pkg::S_EDGE_CAP: begin
                    r_cur  <= so_rdata;
                    r_take <= 1'b0;
                end
                kms_pkg::S_LBL_A: begin
                    r_la <= lb_rdata;
                end
                kms_pkg::S_LBL_B: begin
                    r_lb <= lb_rdata;
                    r_k  <= '0;
                end
                kms_pkg::S_SWEEP: begin
                    r_k <= r_k + NW'(1);
                    if (k_end) begin
                        r_fresh <= r_fresh + LW'(1);
                        r_take  <= 1'b1;
                    end
                end
                kms_pkg::S_EMIT: begin
                    o_valid       <= 1'b1;
                    o_out_node_a  <= r_cur[EDW-1 -: NW4];
                    o_out_node_b  <= r_cur[EDW-NW4-1 -: NW4];
                    o_out_weight  <= r_cur[WW-1:0];
                    o_in_tree     <= r_take;
                    o_overflow    <= r_dropped;
                    o_last_result <= e_end;
                    r_e           <= r_e + EW'(1);
                    if (e_end) begin
                        r_count   <= '0;
                        r_dropped <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    kms_ram #(.DEPTH(MAX_EDGES), .WIDTH(EDW)) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    kms_ram #(.DEPTH(MAX_EDGES), .WIDTH(EDW)) u_sorted (
        .i_clk   (i_clk),
        .i_we    (so_we),
        .i_waddr (r_rank),
        .i_wdata (r_cur),
        .i_raddr (so_raddr),
        .o_rdata (so_rdata)
    );

    kms_ram #(.DEPTH(MAX_NODES), .WIDTH(LW)) u_label (
        .i_clk   (i_clk),
        .i_we    (lb_we_q),
        .i_waddr (lb_waddr),
        .i_wdata (lb_wdata),
        .i_raddr (lb_raddr),
        .o_rdata (lb_rdata)
    );

`include "assert_macros.svh"
    `KMS_ASSERT(a_strobe_gap, i_clk, i_rst_n, o_valid |=> !o_valid)
    `KMS_ASSERT(a_load_quiet, i_clk, i_rst_n, (start && !busy) |=> !o_valid)
    `KMS_ASSERT(a_last_busy, i_clk, i_rst_n, (start && !busy && i_last) |=> busy)
    `KMS_ASSERT(a_count_cap, i_clk, i_rst_n, r_count <= CW'(MAX_EDGES))
endmodule
